>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define AIPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define AIPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/aips_pkg.sv
// Constants and types of the averaged incremental PID speed unit.
`timescale 1ns / 1ps

package aips_pkg;

   // Sliding window of interval errors.
   localparam int WINDOW = 20;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   // Field widths.
   localparam int PI_W     = 20;
   localparam int ERR_W    = 21;
   localparam int GAIN_W   = 24;
   localparam int DRIVE_W  = 10;

   // Window sum and mean: |sum| needs MAG_W bits, the sum itself one more.
   localparam int MAG_W       = PI_W + $clog2(WINDOW);
   localparam int SUM_W       = MAG_W + 1;
   localparam int MEAN_SHIFT  = MAG_W + $clog2(WINDOW);
   localparam int MEAN_MULT_W = MAG_W + 1;
   localparam int MEAN_PROD_W = MAG_W + MEAN_MULT_W;
   localparam logic [MEAN_MULT_W-1:0] MEAN_MULT = MEAN_MULT_W'(
      ((64'd1 << MEAN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   // PID increment arithmetic.
   localparam int COEF_W  = GAIN_W + 2;
   localparam int PROD_W  = COEF_W + 1 + ERR_W;
   localparam int DELTA_W = PROD_W + 2;

   // Drive accumulator holds drive * 256e6, clamped to 0..1000 drive.
   localparam int ACC_W     = 38;
   localparam int ACC_SUM_W = DELTA_W + 1;
   localparam logic [ACC_W-1:0] ACC_MAX = 38'd256000000000;

   // Drive = accum / 256e6 = (accum >> 11) / 125000 by reciprocal multiply.
   localparam int DRV_PRE_SHIFT = 11;
   localparam int DRV_X_W       = ACC_W - DRV_PRE_SHIFT;
   localparam int DRV_MULT_W    = 28;
   localparam logic [DRV_MULT_W-1:0] DRV_MULT = 28'd140737489;
   localparam int DRV_SHIFT     = 44;
   localparam int DRV_PROD_W    = DRV_X_W + DRV_MULT_W;

   // Register file.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D   = 2'd3;

   localparam logic [PI_W-1:0] SETPOINT_RESET = 20'd2000;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam err_type ERROR_HIST_RESET = 21'sd10;

endpackage

>>> rtl/averaged_incremental_pid_speed_unit.sv
// Top level of the averaged incremental PID speed unit.
`timescale 1ns / 1ps
// A result appears on rsp_valid when its transaction enters the output register.
// Throughput: one transaction per cycle unless rsp_stall backs up the pipeline; the window
// sum and the drive accumulator are read-modify-write loops and the window memory is forwarded.
// Reset (synchronous): the window is empty (all zero), setpoint 2000, gains zero,
// error history ten, drive accumulator zero, no result pending.

module averaged_incremental_pid_speed_unit
   import aips_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [PI_W-1:0]              req_pulse_interval,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DRIVE_W-1:0]           rsp_drive,
   output logic signed [ERR_W-1:0]      rsp_mean_error,

   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers. Change them only while the unit is idle; the unit does not check.
   // ------------------------------------------------------------------
   logic [PI_W-1:0]   setpoint_ff;
   logic [GAIN_W-1:0] gain_p_ff;
   logic [GAIN_W-1:0] gain_i_ff;
   logic [GAIN_W-1:0] gain_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SETPOINT: setpoint_ff <= csr_wdata[PI_W-1:0];
            REG_GAIN_P:   gain_p_ff   <= csr_wdata;
            REG_GAIN_I:   gain_i_ff   <= csr_wdata;
            REG_GAIN_D:   gain_d_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The three increment coefficients are registered so that the gain adds
   // do not sit in front of the multipliers. They follow the gains in the next cycle,
   // which is long before any transaction reaches the multiply stage.
   logic [COEF_W-1:0] coef0_in, coef1_in, coef2_in;
   logic [COEF_W-1:0] coef0_ff, coef1_ff, coef2_ff;

   assign coef0_in = COEF_W'(gain_p_ff) + COEF_W'(gain_i_ff) + COEF_W'(gain_d_ff);
   assign coef1_in = COEF_W'(gain_p_ff) + COEF_W'({gain_d_ff, 1'b0});
   assign coef2_in = COEF_W'(gain_d_ff);

   always_ff @(posedge clock) begin
      coef0_ff <= coef0_in;
      coef1_ff <= coef1_in;
      coef2_ff <= coef2_in;
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. Stage k holds a transaction when stage_v_ff[k]
   // is set. A stage may load when it is empty or its content moves on, so
   // bubbles collapse and the unit keeps accepting while a result waits.
   // Stage 9 is the output register.
   // ------------------------------------------------------------------
   localparam int NSTG = 9;

   logic [NSTG:1] stage_v_ff;
   logic [NSTG:1] stage_en;
   logic          accept;

   always_comb begin
      stage_en[NSTG] = !stage_v_ff[NSTG] || !rsp_stall;
      for (int k = NSTG - 1; k >= 1; k--) begin
         stage_en[k] = !stage_v_ff[k] || stage_en[k+1];
      end
   end

   assign req_stall = reset || !stage_en[1];
   assign accept    = req_valid && !req_stall;

   // move[k] is high when a transaction enters stage k at this edge.
   logic [NSTG:1] move;
   always_comb begin
      move[1] = accept;
      for (int k = 2; k <= NSTG; k++) begin
         move[k] = stage_v_ff[k-1] && stage_en[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            stage_v_ff[1] <= accept;
         end
         for (int k = 2; k <= NSTG; k++) begin
            if (stage_en[k]) begin
               stage_v_ff[k] <= stage_v_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: error and window memory read. The memory is read at the
   // oldest slot when the transaction is accepted; the entry is replaced
   // when the transaction leaves stage 1.
   // ------------------------------------------------------------------
   err_type           win_mem [WINDOW];
   logic [WINDOW-1:0] win_vld_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;

   err_type           err_in;
   err_type           err1_ff;
   logic [SLOT_W-1:0] slot1_ff;
   err_type           rd_data_ff;
   logic              fwd1_ff;
   err_type           fwd_data1_ff;

   assign err_in  = $signed({1'b0, req_pulse_interval}) - $signed({1'b0, setpoint_ff});
   assign slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         win_vld_ff <= '0;
      end else begin
         if (accept) begin
            slot_ff <= slot_in;
         end
         if (move[2]) begin
            win_vld_ff[slot1_ff] <= 1'b1;
         end
      end
   end

   // Memory port: one read at acceptance, one write as stage 1 drains.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= win_mem[slot_ff];
      end
      if (move[2]) begin
         win_mem[slot1_ff] <= err1_ff;
      end
   end

   // When the entry being read is written at the same edge (a one-entry
   // window), the read returns stale data, so the written error is forwarded.
   always_ff @(posedge clock) begin
      if (accept) begin
         err1_ff      <= err_in;
         slot1_ff     <= slot_ff;
         fwd1_ff      <= move[2] && (slot1_ff == slot_ff);
         fwd_data1_ff <= err1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: window sum update. The sum register itself is stage 2 data,
   // because it changes only when a transaction enters stage 2.
   // ------------------------------------------------------------------
   err_type                  old_err;
   logic signed [SUM_W-1:0]  window_sum_ff;
   logic signed [SUM_W-1:0]  window_sum_in;

   always_comb begin
      if (fwd1_ff) begin
         old_err = fwd_data1_ff;
      end else if (win_vld_ff[slot1_ff]) begin
         old_err = rd_data_ff;
      end else begin
         old_err = '0;
      end
   end

   assign window_sum_in = window_sum_ff - SUM_W'(old_err) + SUM_W'(err1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff <= '0;
      end else if (move[2]) begin
         window_sum_ff <= window_sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: magnitude of the sum times the reciprocal of the window size.
   // Flooring the magnitude and restoring the sign truncates toward zero.
   // ------------------------------------------------------------------
   logic [MAG_W-1:0]        sum_mag;
   logic [MEAN_PROD_W-1:0]  mean_prod_in;
   logic [MEAN_PROD_W-1:0]  mean_prod3_ff;
   logic                    mean_neg3_ff;

   assign sum_mag      = window_sum_ff[SUM_W-1] ? MAG_W'(-window_sum_ff)
                                                : MAG_W'(window_sum_ff);
   assign mean_prod_in = MEAN_PROD_W'(sum_mag) * MEAN_PROD_W'(MEAN_MULT);

   always_ff @(posedge clock) begin
      if (move[3]) begin
         mean_prod3_ff <= mean_prod_in;
         mean_neg3_ff  <= window_sum_ff[SUM_W-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: signed mean and the error history. The history shifts as a
   // transaction enters stage 4, and each transaction carries its own copy
   // of the two earlier means.
   // ------------------------------------------------------------------
   logic [PI_W-1:0] mean_mag;
   err_type         mean_in;
   err_type         err_now_ff, err_prev_ff;
   err_type         mean4_ff, e1_4_ff, e2_4_ff;

   assign mean_mag = mean_prod3_ff[MEAN_SHIFT +: PI_W];
   assign mean_in  = mean_neg3_ff ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         err_now_ff  <= ERROR_HIST_RESET;
         err_prev_ff <= ERROR_HIST_RESET;
      end else if (move[4]) begin
         err_now_ff  <= mean_in;
         err_prev_ff <= err_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move[4]) begin
         mean4_ff <= mean_in;
         e1_4_ff  <= err_now_ff;
         e2_4_ff  <= err_prev_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: the three coefficient products, one multiplier each.
   // ------------------------------------------------------------------
   prod_type p0_in, p1_in, p2_in;
   prod_type p0_5_ff, p1_5_ff, p2_5_ff;
   err_type  mean5_ff;

   assign p0_in = $signed({1'b0, coef0_ff}) * mean4_ff;
   assign p1_in = $signed({1'b0, coef1_ff}) * e1_4_ff;
   assign p2_in = $signed({1'b0, coef2_ff}) * e2_4_ff;

   always_ff @(posedge clock) begin
      if (move[5]) begin
         p0_5_ff  <= p0_in;
         p1_5_ff  <= p1_in;
         p2_5_ff  <= p2_in;
         mean5_ff <= mean4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: the increment in accumulator units. No rounding occurs.
   // ------------------------------------------------------------------
   logic signed [DELTA_W-1:0] delta_in;
   logic signed [DELTA_W-1:0] delta6_ff;
   err_type                   mean6_ff;

   assign delta_in = DELTA_W'(p0_5_ff) - DELTA_W'(p1_5_ff) + DELTA_W'(p2_5_ff);

   always_ff @(posedge clock) begin
      if (move[6]) begin
         delta6_ff <= delta_in;
         mean6_ff  <= mean5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: accumulate and clamp to 0..1000 drive. The accumulator is
   // stage 7 data, like the window sum in stage 2.
   // ------------------------------------------------------------------
   logic signed [ACC_SUM_W-1:0] acc_sum;
   logic [ACC_W-1:0]            drive_accum_in;
   logic [ACC_W-1:0]            drive_accum_ff;
   err_type                     mean7_ff;

   assign acc_sum = ACC_SUM_W'($signed({1'b0, drive_accum_ff})) + ACC_SUM_W'(delta6_ff);

   always_comb begin
      if (acc_sum[ACC_SUM_W-1]) begin
         drive_accum_in = '0;
      end else if (acc_sum[ACC_SUM_W-2:0] > (ACC_SUM_W - 1)'(ACC_MAX)) begin
         drive_accum_in = ACC_MAX;
      end else begin
         drive_accum_in = acc_sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_accum_ff <= '0;
      end else if (move[7]) begin
         drive_accum_ff <= drive_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move[7]) begin
         mean7_ff <= mean6_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: drive scaling by a reciprocal multiply, exact over the
   // clamped range of the accumulator.
   // ------------------------------------------------------------------
   logic [DRV_PROD_W-1:0] drv_prod_in;
   logic [DRV_PROD_W-1:0] drv_prod8_ff;
   err_type               mean8_ff;

   assign drv_prod_in = DRV_PROD_W'(drive_accum_ff[ACC_W-1:DRV_PRE_SHIFT])
                        * DRV_PROD_W'(DRV_MULT);

   always_ff @(posedge clock) begin
      if (move[8]) begin
         drv_prod8_ff <= drv_prod_in;
         mean8_ff     <= mean7_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 9: output register.
   // ------------------------------------------------------------------
   logic [DRIVE_W-1:0] rsp_drive_ff;
   err_type            rsp_mean_ff;

   always_ff @(posedge clock) begin
      if (move[9]) begin
         rsp_drive_ff <= drv_prod8_ff[DRV_SHIFT +: DRIVE_W];
         rsp_mean_ff  <= mean8_ff;
      end
   end

   assign rsp_valid      = stage_v_ff[NSTG];
   assign rsp_drive      = rsp_drive_ff;
   assign rsp_mean_error = rsp_mean_ff;

endmodule

>>> rtl/aips_checker.sv
// Port-level assertion checker of the averaged incremental PID speed unit, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aips_checker
   import aips_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [PI_W-1:0]         req_pulse_interval,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [DRIVE_W-1:0]      rsp_drive,
   input logic signed [ERR_W-1:0] rsp_mean_error,
   input logic                    csr_we,
   input logic [CSR_IDX_W-1:0]    csr_index,
   input logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Reset drops any pending result.
   `AIPS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   // The clamp keeps the drive within its range.
   `AIPS_ASSERT(a_drive_range, clock, reset, rsp_valid |-> (rsp_drive <= 10'd1000), "drive above 1000")

   // The mean of errors that never reach the most negative code cannot reach it either.
   `AIPS_ASSERT(a_mean_range, clock, reset, rsp_valid |-> (rsp_mean_error != -21'sd1048576), "mean error out of range")

   // A stalled result holds.
   `AIPS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive) && $stable(rsp_mean_error)), "stalled result changed")

endmodule

bind averaged_incremental_pid_speed_unit aips_checker u_aips_checker (.*);
